[hw/rtl/binary_blob_contour_tracer_assert.svh]
// Assertion macros for the contour tracer.
`ifndef BINARY_BLOB_CONTOUR_TRACER_ASSERT_SVH
`define BINARY_BLOB_CONTOUR_TRACER_ASSERT_SVH

// same-cycle implication
`define BBCT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bbct: same-cycle check failed");

// next-cycle implication
`define BBCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bbct: next-cycle check failed");

`endif

[hw/rtl/bbct_pkg.sv]
`default_nettype none
package bbct_pkg;

   localparam int COORD_W     = 6;
   localparam int DIM_W       = 7;
   localparam int VALUE_W     = 8;
   localparam int COORD_LIMIT = 64;
   localparam int NUM_DIRS    = 4;

   localparam logic [VALUE_W-1:0] FG_VALUE = 8'd255;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_FIND    = 2'd1,
      CMD_ADVANCE = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_DOWN  = 2'd2,
      DIR_LEFT  = 2'd3
   } dir_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TRACE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic wr_pixel;
      logic rsp_echo;
      logic rsp_zero;
      logic rsp_nostart;
      logic scan_init;
      logic scan_step;
      logic scan_hit;
      logic scan_miss;
      logic adv_init;
      logic adv_step;
      logic adv_hit;
      logic adv_miss;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic start_valid;
      logic img_empty;
      logic hit;
      logic scan_end;
      logic adv_end;
   } sts_type;

endpackage
`default_nettype wire

[hw/rtl/bbct_ram.sv]
`default_nettype none
module bbct_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hw/rtl/bbct_ctrl.sv]
`default_nettype none
module bbct_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_command,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  bbct_pkg::sts_type sts,
   output bbct_pkg::ctl_type ctl
);

   bbct_pkg::state_type state_ff, state_in;
   bbct_pkg::cmd_type   cmd;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                slot_free;
   logic                accept;
   logic                done;

   assign cmd       = bbct_pkg::cmd_type'(req_command);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == bbct_pkg::ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bbct_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (cmd) inside
                  bbct_pkg::CMD_FIND: begin
                     if (!sts.img_empty) state_in = bbct_pkg::ST_SCAN;
                  end
                  bbct_pkg::CMD_ADVANCE: begin
                     if (sts.start_valid) state_in = bbct_pkg::ST_TRACE;
                  end
                  bbct_pkg::CMD_LOAD, bbct_pkg::CMD_NONE: state_in = bbct_pkg::ST_IDLE;
               endcase
            end
         end
         bbct_pkg::ST_SCAN: begin
            if (sts.hit || sts.scan_end) state_in = bbct_pkg::ST_IDLE;
         end
         bbct_pkg::ST_TRACE: begin
            if (sts.hit || sts.adv_end) state_in = bbct_pkg::ST_IDLE;
         end
         default: state_in = bbct_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctl  = '0;
      done = 1'b0;
      unique case (state_ff)
         bbct_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  bbct_pkg::CMD_LOAD: begin
                     ctl.wr_pixel = 1'b1;
                     ctl.rsp_echo = 1'b1;
                     done         = 1'b1;
                  end
                  bbct_pkg::CMD_FIND: begin
                     if (sts.img_empty) begin
                        ctl.scan_miss = 1'b1;
                        done          = 1'b1;
                     end else begin
                        ctl.scan_init = 1'b1;
                     end
                  end
                  bbct_pkg::CMD_ADVANCE: begin
                     if (sts.start_valid) begin
                        ctl.adv_init = 1'b1;
                     end else begin
                        ctl.rsp_nostart = 1'b1;
                        done            = 1'b1;
                     end
                  end
                  bbct_pkg::CMD_NONE: begin
                     ctl.rsp_zero = 1'b1;
                     done         = 1'b1;
                  end
               endcase
            end
         end
         bbct_pkg::ST_SCAN: begin
            if (sts.hit) begin
               ctl.scan_hit = 1'b1;
               done         = 1'b1;
            end else if (sts.scan_end) begin
               ctl.scan_miss = 1'b1;
               done          = 1'b1;
            end else begin
               ctl.scan_step = 1'b1;
            end
         end
         bbct_pkg::ST_TRACE: begin
            if (sts.hit) begin
               ctl.adv_hit = 1'b1;
               done        = 1'b1;
            end else if (sts.adv_end) begin
               ctl.adv_miss = 1'b1;
               done         = 1'b1;
            end else begin
               ctl.adv_step = 1'b1;
            end
         end
         default: begin
            ctl  = '0;
            done = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bbct_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/bbct_dp.sv]
`default_nettype none
module bbct_dp #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [bbct_pkg::DIM_W-1:0]    csr_wr_data,
   input  logic [bbct_pkg::COORD_W-1:0]  req_pixel_x,
   input  logic [bbct_pkg::COORD_W-1:0]  req_pixel_y,
   input  logic [bbct_pkg::VALUE_W-1:0]  req_pixel_value,
   output logic [bbct_pkg::COORD_W-1:0]  rsp_point_x,
   output logic [bbct_pkg::COORD_W-1:0]  rsp_point_y,
   output logic                          rsp_found,
   output logic                          rsp_closed,
   input  bbct_pkg::ctl_type             ctl,
   output bbct_pkg::sts_type             sts
);

   localparam int DW   = bbct_pkg::DIM_W;
   localparam int XW   = bbct_pkg::COORD_W;
   localparam int COLS = (MAX_WIDTH < bbct_pkg::COORD_LIMIT) ? MAX_WIDTH : bbct_pkg::COORD_LIMIT;
   localparam int ROWS = (MAX_HEIGHT < bbct_pkg::COORD_LIMIT) ? MAX_HEIGHT
                                                                : bbct_pkg::COORD_LIMIT;
   localparam int CW   = $clog2(COLS);
   localparam int RW   = $clog2(ROWS);
   localparam int AW   = CW + RW;
   localparam int KW   = $clog2(bbct_pkg::NUM_DIRS) + 1;

   logic [DW-1:0]     cfg_w_ff, cfg_w_in, cfg_h_ff, cfg_h_in;
   logic [CW-1:0]     start_col_ff, start_col_in, cur_col_ff, cur_col_in;
   logic [RW-1:0]     start_row_ff, start_row_in, cur_row_ff, cur_row_in;
   bbct_pkg::dir_type heading_ff, heading_in;
   logic              start_valid_ff, start_valid_in;
   logic [CW-1:0]     sc_col_ff, sc_col_in;
   logic [RW-1:0]     sc_row_ff, sc_row_in;
   logic              sc_act_ff, sc_act_in;
   logic [KW-1:0]     k_ff, k_in;
   logic              pr_valid_ff, pr_valid_in;
   logic [CW-1:0]     pr_x_ff, pr_x_in;
   logic [RW-1:0]     pr_y_ff, pr_y_in;
   bbct_pkg::dir_type pr_dir_ff, pr_dir_in;
   logic              pr_inb_ff, pr_inb_in;
   logic [XW-1:0]     rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic              rsp_found_ff, rsp_found_in, rsp_closed_ff, rsp_closed_in;

   logic [DW-1:0]     w_eff, h_eff;
   logic [DW-1:0]     col_next, row_next;
   bbct_pkg::dir_type cand_dir;
   logic [CW:0]       nb_x;
   logic [RW:0]       nb_y;
   logic              nb_neg;
   logic              nb_inb;
   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic              wr_data, rd_data;

   assign w_eff = (cfg_w_ff > DW'(COLS)) ? DW'(COLS) : cfg_w_ff;
   assign h_eff = (cfg_h_ff > DW'(ROWS)) ? DW'(ROWS) : cfg_h_ff;

   assign col_next = DW'(sc_col_ff) + DW'(1);
   assign row_next = DW'(sc_row_ff) + DW'(1);

   // candidate direction: left of heading first, then straight, right, back
   assign cand_dir = bbct_pkg::dir_type'(2'(heading_ff + 2'd3 + k_ff[1:0]));

   always_comb begin
      nb_x   = {1'b0, cur_col_ff};
      nb_y   = {1'b0, cur_row_ff};
      nb_neg = 1'b0;
      unique case (cand_dir)
         bbct_pkg::DIR_UP: begin
            if (cur_row_ff == '0) nb_neg = 1'b1;
            else nb_y = nb_y - (RW+1)'(1);
         end
         bbct_pkg::DIR_RIGHT: nb_x = nb_x + (CW+1)'(1);
         bbct_pkg::DIR_DOWN:  nb_y = nb_y + (RW+1)'(1);
         bbct_pkg::DIR_LEFT: begin
            if (cur_col_ff == '0) nb_neg = 1'b1;
            else nb_x = nb_x - (CW+1)'(1);
         end
      endcase
   end

   assign nb_inb = !nb_neg && (DW'(nb_x) < w_eff) && (DW'(nb_y) < h_eff);

   assign wr_en   = ctl.wr_pixel && (DW'(req_pixel_x) < DW'(COLS))
                                 && (DW'(req_pixel_y) < DW'(ROWS));
   assign wr_addr = {req_pixel_y[RW-1:0], req_pixel_x[CW-1:0]};
   assign wr_data = (req_pixel_value == bbct_pkg::FG_VALUE);
   assign rd_addr = ctl.adv_step ? {nb_y[RW-1:0], nb_x[CW-1:0]} : {sc_row_ff, sc_col_ff};

   bbct_ram #(
      .WIDTH (1),
      .DEPTH (2**AW)
   ) u_pixels (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      cfg_w_in       = cfg_w_ff;
      cfg_h_in       = cfg_h_ff;
      start_col_in   = start_col_ff;
      start_row_in   = start_row_ff;
      cur_col_in     = cur_col_ff;
      cur_row_in     = cur_row_ff;
      heading_in     = heading_ff;
      start_valid_in = start_valid_ff;
      sc_col_in      = sc_col_ff;
      sc_row_in      = sc_row_ff;
      sc_act_in      = sc_act_ff;
      k_in           = k_ff;
      pr_valid_in    = pr_valid_ff;
      pr_x_in        = pr_x_ff;
      pr_y_in        = pr_y_ff;
      pr_dir_in      = pr_dir_ff;
      pr_inb_in      = pr_inb_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_closed_in  = rsp_closed_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            bbct_pkg::REG_WIDTH:  cfg_w_in = csr_wr_data;
            bbct_pkg::REG_HEIGHT: cfg_h_in = csr_wr_data;
         endcase
      end

      if (ctl.rsp_echo) begin
         rsp_x_in      = req_pixel_x;
         rsp_y_in      = req_pixel_y;
         rsp_found_in  = 1'b0;
         rsp_closed_in = 1'b0;
      end

      if (ctl.rsp_zero) begin
         rsp_x_in      = '0;
         rsp_y_in      = '0;
         rsp_found_in  = 1'b0;
         rsp_closed_in = 1'b0;
      end

      if (ctl.rsp_nostart) begin
         rsp_x_in      = XW'(cur_col_ff);
         rsp_y_in      = XW'(cur_row_ff);
         rsp_found_in  = 1'b0;
         rsp_closed_in = 1'b1;
      end

      if (ctl.scan_init) begin
         sc_col_in   = '0;
         sc_row_in   = '0;
         sc_act_in   = 1'b1;
         pr_valid_in = 1'b0;
      end

      // raster walk, one read issued per cycle
      if (ctl.scan_step) begin
         if (sc_act_ff) begin
            pr_valid_in = 1'b1;
            pr_x_in     = sc_col_ff;
            pr_y_in     = sc_row_ff;
            pr_dir_in   = bbct_pkg::DIR_UP;
            pr_inb_in   = 1'b1;
            if (col_next == w_eff) begin
               sc_col_in = '0;
               if (row_next == h_eff) sc_act_in = 1'b0;
               else sc_row_in = row_next[RW-1:0];
            end else begin
               sc_col_in = col_next[CW-1:0];
            end
         end else begin
            pr_valid_in = 1'b0;
         end
      end

      if (ctl.scan_hit) begin
         start_col_in   = pr_x_ff;
         start_row_in   = pr_y_ff;
         cur_col_in     = pr_x_ff;
         cur_row_in     = pr_y_ff;
         heading_in     = bbct_pkg::DIR_UP;
         start_valid_in = 1'b1;
         rsp_x_in       = XW'(pr_x_ff);
         rsp_y_in       = XW'(pr_y_ff);
         rsp_found_in   = 1'b1;
         rsp_closed_in  = 1'b0;
      end

      if (ctl.scan_miss) begin
         start_valid_in = 1'b0;
         rsp_x_in       = '0;
         rsp_y_in       = '0;
         rsp_found_in   = 1'b0;
         rsp_closed_in  = 1'b0;
      end

      if (ctl.adv_init) begin
         k_in        = '0;
         pr_valid_in = 1'b0;
      end

      // one neighbour probe issued per cycle
      if (ctl.adv_step) begin
         if (k_ff != KW'(bbct_pkg::NUM_DIRS)) begin
            pr_valid_in = 1'b1;
            pr_x_in     = nb_x[CW-1:0];
            pr_y_in     = nb_y[RW-1:0];
            pr_dir_in   = cand_dir;
            pr_inb_in   = nb_inb;
            k_in        = k_ff + KW'(1);
         end else begin
            pr_valid_in = 1'b0;
         end
      end

      if (ctl.adv_hit) begin
         cur_col_in    = pr_x_ff;
         cur_row_in    = pr_y_ff;
         heading_in    = pr_dir_ff;
         rsp_x_in      = XW'(pr_x_ff);
         rsp_y_in      = XW'(pr_y_ff);
         rsp_found_in  = 1'b1;
         rsp_closed_in = (pr_x_ff == start_col_ff) && (pr_y_ff == start_row_ff);
      end

      if (ctl.adv_miss) begin
         rsp_x_in      = XW'(cur_col_ff);
         rsp_y_in      = XW'(cur_row_ff);
         rsp_found_in  = 1'b1;
         rsp_closed_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff       <= DW'(bbct_pkg::COORD_LIMIT);
         cfg_h_ff       <= DW'(bbct_pkg::COORD_LIMIT);
         start_col_ff   <= '0;
         start_row_ff   <= '0;
         cur_col_ff     <= '0;
         cur_row_ff     <= '0;
         heading_ff     <= bbct_pkg::DIR_UP;
         start_valid_ff <= 1'b0;
         sc_act_ff      <= 1'b0;
         k_ff           <= '0;
         pr_valid_ff    <= 1'b0;
      end else begin
         cfg_w_ff       <= cfg_w_in;
         cfg_h_ff       <= cfg_h_in;
         start_col_ff   <= start_col_in;
         start_row_ff   <= start_row_in;
         cur_col_ff     <= cur_col_in;
         cur_row_ff     <= cur_row_in;
         heading_ff     <= heading_in;
         start_valid_ff <= start_valid_in;
         sc_act_ff      <= sc_act_in;
         k_ff           <= k_in;
         pr_valid_ff    <= pr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sc_col_ff     <= sc_col_in;
      sc_row_ff     <= sc_row_in;
      pr_x_ff       <= pr_x_in;
      pr_y_ff       <= pr_y_in;
      pr_dir_ff     <= pr_dir_in;
      pr_inb_ff     <= pr_inb_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_closed_ff <= rsp_closed_in;
   end

   assign sts.start_valid = start_valid_ff;
   assign sts.img_empty   = (w_eff == '0) || (h_eff == '0);
   assign sts.hit         = pr_valid_ff && pr_inb_ff && rd_data;
   assign sts.scan_end    = !sc_act_ff;
   assign sts.adv_end     = (k_ff == KW'(bbct_pkg::NUM_DIRS));

   assign rsp_point_x = rsp_x_ff;
   assign rsp_point_y = rsp_y_ff;
   assign rsp_found   = rsp_found_ff;
   assign rsp_closed  = rsp_closed_ff;

endmodule
`default_nettype wire

[hw/rtl/binary_blob_contour_tracer.sv]
// Channel   Ports                                          Direction
// request   req_valid/req_ready, command, pixel x/y/value  in
// response  rsp_valid/rsp_ready, point x/y, found, closed  out
// csr       csr_wr_en, csr_index, csr_wr_data              in, write only
//
// Load, unused command and advance without a start point are answered from idle.
// Advance: one neighbour probe per cycle through the single registered read
//   port of the pixel memory.
// Find start: raster scan up to the first foreground pixel, whole image on a miss.
// Synchronous reset; pixel memory is not cleared.
// A held response stalls request acceptance; busy work never stalls.
`default_nettype none
`include "binary_blob_contour_tracer_assert.svh"
module binary_blob_contour_tracer #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_command,
   input  logic [bbct_pkg::COORD_W-1:0]  req_pixel_x,
   input  logic [bbct_pkg::COORD_W-1:0]  req_pixel_y,
   input  logic [bbct_pkg::VALUE_W-1:0]  req_pixel_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bbct_pkg::COORD_W-1:0]  rsp_point_x,
   output logic [bbct_pkg::COORD_W-1:0]  rsp_point_y,
   output logic                          rsp_found,
   output logic                          rsp_closed,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [bbct_pkg::DIM_W-1:0]    csr_wr_data
);

   bbct_pkg::ctl_type ctl;
   bbct_pkg::sts_type sts;

   bbct_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .sts         (sts),
      .ctl         (ctl)
   );

   bbct_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_pixel_value (req_pixel_value),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_found       (rsp_found),
      .rsp_closed      (rsp_closed),
      .ctl             (ctl),
      .sts             (sts)
   );

   // output register stays empty while a scan or trace is in progress
   `BBCT_ASSERT_SAME(a_busy_rsp_empty, clock, reset, ctl.scan_step || ctl.adv_step, !rsp_valid)
   `BBCT_ASSERT_NEXT(a_load_answers, clock, reset, req_valid && req_ready && req_command == bbct_pkg::CMD_LOAD, rsp_valid)
   `BBCT_ASSERT_SAME(a_full_blocks_req, clock, reset, rsp_valid && !rsp_ready, !req_ready)

endmodule
`default_nettype wire

[test/binary_blob_contour_tracer_test.sv]
module binary_blob_contour_tracer_test;
   import bbct_pkg::*;

   localparam int IMG_SIZE     = 64;
   localparam int CYCLE_LIMIT  = 2500000;
   localparam int RANDOM_ITEMS = 1200;
   localparam int NUM_PHASES   = 6;

   typedef struct packed {
      cmd_type              command;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
      logic [VALUE_W-1:0]   value;
   } trace_req_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               found;
      logic               closed;
   } trace_point_type;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_ready;
   trace_req_type      req_item    = '0;
   logic               rsp_valid;
   logic               rsp_ready   = 1'b0;
   logic [COORD_W-1:0] rsp_point_x;
   logic [COORD_W-1:0] rsp_point_y;
   logic               rsp_found;
   logic               rsp_closed;
   logic               csr_wr_en   = 1'b0;
   logic               csr_index   = REG_WIDTH;
   logic [DIM_W-1:0]   csr_wr_data = '0;

   // tracer state as predicted
   bit                 pixels [0:IMG_SIZE-1][0:IMG_SIZE-1];
   logic [DIM_W-1:0]   width_set   = 7'd64;
   logic [DIM_W-1:0]   height_set  = 7'd64;
   logic [COORD_W-1:0] start_col   = '0;
   logic [COORD_W-1:0] start_row   = '0;
   logic [COORD_W-1:0] cur_col     = '0;
   logic [COORD_W-1:0] cur_row     = '0;
   dir_type            heading     = DIR_UP;
   bit                 start_valid = 1'b0;

   // foreground as it will stand once every queued load is done
   bit                 planned_fg [0:IMG_SIZE-1][0:IMG_SIZE-1];

   trace_req_type      pending_reqs[$];
   trace_point_type    expected_points[$];
   int                 queued    = 0;
   bit                 failed    = 1'b0;
   int                 cycles    = 0;
   logic               req_taken = 1'b0;
   logic               rsp_taken = 1'b0;
   int                 req_wait  = 0;
   int                 rsp_wait  = 0;
   int                 req_calm  = 0;
   int                 rsp_calm  = 0;

   binary_blob_contour_tracer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_item.command),
      .req_pixel_x     (req_item.x),
      .req_pixel_y     (req_item.y),
      .req_pixel_value (req_item.value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_found       (rsp_found),
      .rsp_closed      (rsp_closed),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic int clamp_dim(input logic [DIM_W-1:0] v);
      return (v > COORD_LIMIT) ? COORD_LIMIT : int'(v);
   endfunction

   function automatic bit is_fg(input int x, input int y);
      if (x < 0 || y < 0 || x >= clamp_dim(width_set) || y >= clamp_dim(height_set))
         return 1'b0;
      return pixels[y][x];
   endfunction

   function automatic trace_point_type trace_step(input trace_req_type q);
      trace_point_type res;
      int w, h, r, c, k, nx, ny;
      bit hit, moved;
      logic [1:0] dsum;
      dir_type d;
      res = '0;
      w = clamp_dim(width_set);
      h = clamp_dim(height_set);
      case (q.command)
         CMD_LOAD: begin
            pixels[q.y][q.x] = (q.value == FG_VALUE);
            res.x = q.x;
            res.y = q.y;
         end
         CMD_FIND: begin
            hit = 1'b0;
            for (r = 0; r < h; r++)
               for (c = 0; c < w; c++)
                  if (!hit && pixels[r][c]) begin
                     start_col = COORD_W'(c);
                     start_row = COORD_W'(r);
                     hit = 1'b1;
                  end
            if (hit) begin
               cur_col = start_col;
               cur_row = start_row;
               heading = DIR_UP;
               start_valid = 1'b1;
               res.x = start_col;
               res.y = start_row;
               res.found = 1'b1;
            end else begin
               start_valid = 1'b0;
            end
         end
         CMD_ADVANCE: begin
            if (!start_valid) begin
               res.closed = 1'b1;
            end else begin
               moved = 1'b0;
               // left of heading first, then straight, right, back
               for (k = 0; k < NUM_DIRS; k++) begin
                  if (!moved) begin
                     dsum = heading + 2'd3 + k[1:0];
                     d = dir_type'(dsum);
                     nx = int'(cur_col);
                     ny = int'(cur_row);
                     case (d)
                        DIR_UP:    ny--;
                        DIR_RIGHT: nx++;
                        DIR_DOWN:  ny++;
                        default:   nx--;
                     endcase
                     if (is_fg(nx, ny)) begin
                        cur_col = COORD_W'(nx);
                        cur_row = COORD_W'(ny);
                        heading = d;
                        moved = 1'b1;
                     end
                  end
               end
               res.found = 1'b1;
               res.closed = !moved || (cur_col == start_col && cur_row == start_row);
            end
            res.x = cur_col;
            res.y = cur_row;
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic int draw_pause(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   task automatic queue_load(input int x, input int y, input int v);
      trace_req_type r;
      r.command = CMD_LOAD;
      r.x = x[COORD_W-1:0];
      r.y = y[COORD_W-1:0];
      r.value = v[VALUE_W-1:0];
      planned_fg[y][x] = (v == FG_VALUE);
      pending_reqs.push_back(r);
      queued++;
   endtask

   task automatic queue_cmd(input cmd_type cmd);
      trace_req_type r;
      r.command = cmd;
      r.x = COORD_W'($urandom);
      r.y = COORD_W'($urandom);
      r.value = VALUE_W'($urandom);
      pending_reqs.push_back(r);
      queued++;
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_valid || expected_points.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_dims(input int w, input int h);
      wait_idle();
      repeat (4) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= REG_WIDTH;
      csr_wr_data <= w[DIM_W-1:0];
      @(negedge clock);
      csr_index <= REG_HEIGHT;
      csr_wr_data <= h[DIM_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      width_set = w[DIM_W-1:0];
      height_set = h[DIM_W-1:0];
   endtask

   // clear the old blob, draw a new one, find its start and walk the contour, with stray commands mixed in
   task automatic queue_trace_run(input int w, input int h);
      int x, y, ox, oy, bw, bh, steps;
      bit solid;
      for (y = 0; y < IMG_SIZE; y++)
         for (x = 0; x < IMG_SIZE; x++)
            if (planned_fg[y][x])
               queue_load(x, y, $urandom_range(0, 254));
      bw = $urandom_range(1, 6);
      bh = $urandom_range(1, 6);
      ox = $urandom_range(0, 1) ? $urandom_range(0, (w > 8) ? 7 : w - 1)
                                : $urandom_range(0, w - 1);
      oy = $urandom_range(0, 1) ? $urandom_range(0, (h > 8) ? 7 : h - 1)
                                : $urandom_range(0, h - 1);
      solid = ($urandom_range(0, 2) == 0);
      for (y = oy; y < oy + bh && y < IMG_SIZE; y++)
         for (x = ox; x < ox + bw && x < IMG_SIZE; x++)
            queue_load(x, y, (solid || $urandom_range(0, 2) != 0) ? 255
                                                                  : $urandom_range(0, 254));
      queue_cmd(CMD_FIND);
      steps = $urandom_range(3, 2 * (bw + bh) + 8);
      repeat (steps) begin
         case ($urandom_range(0, 15))
            0: queue_cmd(CMD_NONE);
            1: queue_cmd(CMD_FIND);
            2: queue_load($urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 1) ? 255 : $urandom_range(0, 255));
            default: queue_cmd(CMD_ADVANCE);
         endcase
      end
   endtask

   always @(negedge clock) begin : driver
      int wait_n;
      if (reset) begin
         req_valid <= 1'b0;
         req_wait <= 0;
      end else if (!req_valid || req_taken) begin
         wait_n = req_valid ? draw_pause(req_calm) : req_wait;
         if (wait_n > 0) begin
            req_valid <= 1'b0;
            req_wait <= wait_n - 1;
         end else if (pending_reqs.size() != 0) begin
            req_item <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_wait <= 0;
         end else begin
            req_valid <= 1'b0;
            req_wait <= 0;
         end
      end
   end

   always @(negedge clock) begin : receiver
      int wait_n;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait <= 0;
      end else begin
         wait_n = rsp_taken ? draw_pause(rsp_calm) : rsp_wait;
         if (wait_n == 0) begin
            rsp_ready <= 1'b1;
            rsp_wait <= 0;
         end else begin
            rsp_ready <= 1'b0;
            rsp_wait <= (rsp_valid === 1'b1) ? wait_n - 1 : wait_n;
         end
      end
   end

   always @(posedge clock) begin : monitor
      trace_point_type got, want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         rsp_taken <= rsp_valid && rsp_ready;
         if (req_valid && req_ready)
            expected_points.push_back(trace_step(req_item));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_point_x, rsp_point_y, rsp_found, rsp_closed};
            if (expected_points.size() == 0) begin
               $display("%0t: response with no request outstanding: %s",
                        $time, $sformatf("x=%0d y=%0d found=%0d closed=%0d",
                                         got.x, got.y, got.found, got.closed));
               failed = 1'b1;
            end else begin
               want = expected_points.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected x=%0d y=%0d found=%0d closed=%0d,",
                           $time, want.x, want.y, want.found, want.closed);
                  $display("%0t:          got      x=%0d y=%0d found=%0d closed=%0d",
                           $time, got.x, got.y, got.found, got.closed);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : stimulus
      int x, y, phase, pw, ph, mark;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no start point yet, unused command
      queue_cmd(CMD_ADVANCE);
      queue_cmd(CMD_NONE);

      // write every pixel once so that no read ever hits an unwritten entry
      for (y = 0; y < IMG_SIZE; y++)
         for (x = 0; x < IMG_SIZE; x++)
            queue_load(x, y, $urandom_range(0, 254));

      // empty image, then isolated pixels at both corners, then a pair
      queue_cmd(CMD_FIND);
      queue_cmd(CMD_ADVANCE);
      queue_load(63, 63, 255);
      queue_cmd(CMD_FIND);
      queue_cmd(CMD_ADVANCE);
      queue_load(63, 63, 0);
      queue_load(0, 0, 255);
      queue_load(1, 0, 254);
      queue_cmd(CMD_FIND);
      queue_cmd(CMD_ADVANCE);
      queue_load(1, 0, 255);
      queue_cmd(CMD_ADVANCE);
      queue_cmd(CMD_ADVANCE);
      queue_cmd(CMD_ADVANCE);
      queue_load(0, 0, 0);
      queue_load(1, 0, 0);
      queue_cmd(CMD_NONE);

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin pw = 1;  ph = 1;  end
            1: begin pw = 64; ph = 64; end
            2: begin pw = 1;  ph = 64; end
            3: begin pw = 64; ph = 1;  end
            default: begin
               pw = $urandom_range(1, 64);
               ph = $urandom_range(1, 64);
            end
         endcase
         set_dims(pw, ph);
         mark = queued + RANDOM_ITEMS / NUM_PHASES;
         while (queued < mark)
            queue_trace_run(pw, ph);
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (expected_points.size() != 0)
         $display("%0t: %0d expected responses never arrived", $time, expected_points.size());
      if (!failed && expected_points.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
